// File: rtl/core/vri_pkg.sv
// ----------------------------------------------------------------------------
// vri_pkg
// Shared types, codes, memory layout and address mapping for the video
// register interface.
// ----------------------------------------------------------------------------
package vri_pkg;

    // Item operations
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_VBLANK = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [7:0] MASK_RESET = 8'h1E;

    // Video memory layout: pattern, then nametables, then palette
    localparam int PATTERN_BYTES = 8192;
    localparam int NT_BYTES      = 2048;
    localparam int PAL_BYTES     = 32;
    localparam int NT_BASE       = PATTERN_BYTES;
    localparam int PAL_BASE      = NT_BASE + NT_BYTES;
    localparam int VRAM_DEPTH    = PAL_BASE + PAL_BYTES;
    localparam int VRAM_AW       = $clog2(VRAM_DEPTH);

    localparam int OAM_DEPTH = 256;
    localparam int OAM_AW    = $clog2(OAM_DEPTH);

    localparam logic [13:0] PAL_START = 14'h3F00;

    // Source of the result byte
    typedef enum logic [1:0] {
        RSP_IMM = 2'd0,
        RSP_OAM = 2'd1,
        RSP_BUF = 2'd2,
        RSP_PAL = 2'd3
    } rsp_kind_t;

    typedef struct packed {
        logic               oam_en;
        logic               oam_we;
        logic [OAM_AW-1:0]  oam_addr;
        logic               vram_en;
        logic               vram_we;
        logic [VRAM_AW-1:0] vram_addr;
        logic [7:0]         wdata;
    } mem_req_t;

    typedef struct packed {
        rsp_kind_t  kind;
        logic [7:0] imm;
        logic       nmi;
    } pend_t;

    typedef struct packed {
        logic pend_valid;
    } resp_stat_t;

    // Map a 14-bit video address onto the flat video memory
    function automatic logic [VRAM_AW-1:0] vram_map(input logic [13:0] a, input logic mirror);
        logic       bank;
        logic [4:0] p;
        logic [VRAM_AW-1:0] r;
        bank = mirror ? a[10] : a[11];
        p    = a[4:0];
        if (p[4] && (p[1:0] == 2'b00)) begin
            p[4] = 1'b0;
        end
        if (!a[13]) begin
            r = VRAM_AW'(a[12:0]);
        end else if (a < PAL_START) begin
            r = VRAM_AW'(NT_BASE) + VRAM_AW'({bank, a[9:0]});
        end else begin
            r = VRAM_AW'(PAL_BASE) + VRAM_AW'(p);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/vri_ram.sv
// ----------------------------------------------------------------------------
// vri_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data holds until the next read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/vri_regfile.sv
// ----------------------------------------------------------------------------
// vri_regfile
// Scroll/address registers, control, mask, status and OAM address; issues
// the memory request for each accepted OAM or video data word.
// ----------------------------------------------------------------------------
module vri_regfile (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              acc,
    input  logic [1:0]        operation,
    input  logic [2:0]        register_index,
    input  logic [7:0]        write_data,
    input  logic              mirror,
    output vri_pkg::mem_req_t req,
    output vri_pkg::pend_t    pend
);

    logic [14:0] vram_address_reg, vram_address_next;
    logic [14:0] temp_address_reg, temp_address_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  oam_addr_reg, oam_addr_next;
    logic [14:0] v_inc;
    logic [vri_pkg::VRAM_AW-1:0] v_map;

    assign v_inc = vram_address_reg + (control_reg[2] ? 15'd32 : 15'd1);
    assign v_map = vri_pkg::vram_map(vram_address_reg[13:0], mirror);

    always_comb begin
        vram_address_next = vram_address_reg;
        temp_address_next = temp_address_reg;
        fine_x_next       = fine_x_reg;
        toggle_next       = toggle_reg;
        control_next      = control_reg;
        mask_next         = mask_reg;
        status_next       = status_reg;
        oam_addr_next     = oam_addr_reg;
        req               = '0;
        req.oam_addr      = oam_addr_reg;
        req.vram_addr     = v_map;
        req.wdata         = write_data;
        pend.kind         = vri_pkg::RSP_IMM;
        pend.imm          = 8'd0;
        pend.nmi          = 1'b0;

        case (operation)
            vri_pkg::OP_READ: begin
                case (register_index)
                    vri_pkg::REG_STATUS: begin
                        pend.imm       = {status_reg, 5'd0};
                        status_next[2] = 1'b0;
                        toggle_next    = 1'b0;
                    end
                    vri_pkg::REG_OAMDATA: begin
                        req.oam_en = acc;
                        pend.kind  = vri_pkg::RSP_OAM;
                    end
                    vri_pkg::REG_DATA: begin
                        req.vram_en       = acc;
                        vram_address_next = v_inc;
                        pend.kind = (vram_address_reg[13:0] < vri_pkg::PAL_START) ?
                                    vri_pkg::RSP_BUF : vri_pkg::RSP_PAL;
                    end
                    default: begin
                    end
                endcase
            end
            vri_pkg::OP_WRITE: begin
                case (register_index)
                    vri_pkg::REG_CTRL: begin
                        control_next             = write_data;
                        temp_address_next[11:10] = write_data[1:0];
                    end
                    vri_pkg::REG_MASK: begin
                        mask_next = write_data;
                    end
                    vri_pkg::REG_OAMADDR: begin
                        oam_addr_next = write_data;
                    end
                    vri_pkg::REG_OAMDATA: begin
                        req.oam_en    = acc;
                        req.oam_we    = 1'b1;
                        oam_addr_next = oam_addr_reg + 8'd1;
                    end
                    vri_pkg::REG_SCROLL: begin
                        if (!toggle_reg) begin
                            temp_address_next[4:0] = write_data[7:3];
                            fine_x_next            = write_data[2:0];
                            toggle_next            = 1'b1;
                        end else begin
                            temp_address_next[14:12] = write_data[2:0];
                            temp_address_next[9:5]   = write_data[7:3];
                            toggle_next              = 1'b0;
                        end
                    end
                    vri_pkg::REG_ADDR: begin
                        if (!toggle_reg) begin
                            temp_address_next[14]   = 1'b0;
                            temp_address_next[13:8] = write_data[5:0];
                            toggle_next             = 1'b1;
                        end else begin
                            temp_address_next[7:0] = write_data;
                            vram_address_next      = {temp_address_reg[14:8], write_data};
                            toggle_next            = 1'b0;
                        end
                    end
                    vri_pkg::REG_DATA: begin
                        req.vram_en       = acc;
                        req.vram_we       = 1'b1;
                        vram_address_next = v_inc;
                    end
                    default: begin
                    end
                endcase
            end
            vri_pkg::OP_VBLANK: begin
                status_next[2] = 1'b1;
                pend.nmi       = control_reg[7];
            end
            default: begin
                status_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vram_address_reg <= '0;
            temp_address_reg <= '0;
            fine_x_reg       <= '0;
            toggle_reg       <= 1'b0;
            control_reg      <= '0;
            mask_reg         <= vri_pkg::MASK_RESET;
            status_reg       <= '0;
            oam_addr_reg     <= '0;
        end else if (acc) begin
            vram_address_reg <= vram_address_next;
            temp_address_reg <= temp_address_next;
            fine_x_reg       <= fine_x_next;
            toggle_reg       <= toggle_next;
            control_reg      <= control_next;
            mask_reg         <= mask_next;
            status_reg       <= status_next;
            oam_addr_reg     <= oam_addr_next;
        end
    end

endmodule

// File: rtl/core/vri_resp.sv
// ----------------------------------------------------------------------------
// vri_resp
// Memory-wait stage, delayed read buffer and output register.
// ----------------------------------------------------------------------------
module vri_resp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                acc,
    input  vri_pkg::pend_t      pend,
    input  logic [7:0]          oam_rdata,
    input  logic [7:0]          vram_rdata,
    input  logic                m_ready,
    output logic                in_ready,
    output logic                m_valid,
    output logic [7:0]          m_read_data,
    output logic                m_nmi_request,
    output vri_pkg::resp_stat_t stat
);

    logic           pend_valid_reg, pend_valid_next;
    vri_pkg::pend_t pend_reg;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_data_reg, out_data_next;
    logic           out_nmi_reg;
    logic [7:0]     rbuf_reg, rbuf_next;
    logic           pend_go;

    assign pend_go  = pend_valid_reg && (!out_valid_reg || m_ready);
    assign in_ready = !pend_valid_reg || pend_go;

    always_comb begin
        rbuf_next = rbuf_reg;
        case (pend_reg.kind)
            vri_pkg::RSP_OAM: out_data_next = oam_rdata;
            vri_pkg::RSP_PAL: out_data_next = vram_rdata;
            vri_pkg::RSP_BUF: begin
                out_data_next = rbuf_reg;
                rbuf_next     = vram_rdata;
            end
            default: out_data_next = pend_reg.imm;
        endcase
        pend_valid_next = acc ? 1'b1 : (pend_go ? 1'b0 : pend_valid_reg);
        out_valid_next  = pend_go ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rbuf_reg       <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (pend_go) begin
                rbuf_reg <= rbuf_next;
            end
        end
    end

    // Payload: capture on accept, advance on handoff
    always_ff @(posedge aclk) begin
        if (acc) begin
            pend_reg <= pend;
        end
        if (pend_go) begin
            out_data_reg <= out_data_next;
            out_nmi_reg  <= pend_reg.nmi;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_read_data     = out_data_reg;
    assign m_nmi_request   = out_nmi_reg;
    assign stat.pend_valid = pend_valid_reg;

endmodule

// File: rtl/core/video_register_interface_top.sv
// ----------------------------------------------------------------------------
// video_register_interface_top: host register file of a tile video processor
// Result path: memory read into the wait stage, then the output register.
// Throughput: one word per cycle while the output is not stalled; each word makes at most one OAM or video RAM access.
// Reset: register file clears except mask (0x1E); memories hold until written.
// ----------------------------------------------------------------------------
module video_register_interface_top (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: mirroring mode (0 horizontal, 1 vertical)
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // input words
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [2:0] s_register_index,
    input  logic [7:0] s_write_data,
    // result words
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_nmi_request
);

    logic                mirror_reg;
    logic                acc;
    vri_pkg::mem_req_t   req;
    vri_pkg::pend_t      pend;
    vri_pkg::resp_stat_t stat;
    logic [7:0]          oam_rdata;
    logic [7:0]          vram_rdata;

    // Mirroring register; writes must arrive only while the block is idle; the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            mirror_reg <= cfg_data;
        end
    end

    assign acc = s_valid && s_ready;

    // Stage 1: update registers and launch the memory access on accept
    vri_regfile u_regfile (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .acc            (acc),
        .operation      (s_operation),
        .register_index (s_register_index),
        .write_data     (s_write_data),
        .mirror         (mirror_reg),
        .req            (req),
        .pend           (pend)
    );

    // Sprite attribute memory
    vri_ram #(
        .WIDTH (8),
        .DEPTH (vri_pkg::OAM_DEPTH)
    ) u_oam (
        .aclk  (aclk),
        .en    (req.oam_en),
        .we    (req.oam_we),
        .addr  (req.oam_addr),
        .wdata (req.wdata),
        .rdata (oam_rdata)
    );

    // Pattern, nametable and palette storage in one flat memory
    vri_ram #(
        .WIDTH (8),
        .DEPTH (vri_pkg::VRAM_DEPTH)
    ) u_vram (
        .aclk  (aclk),
        .en    (req.vram_en),
        .we    (req.vram_we),
        .addr  (req.vram_addr),
        .wdata (req.wdata),
        .rdata (vram_rdata)
    );

    // Stage 2: pick the result byte, hold the read buffer, drive the output
    vri_resp u_resp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .acc           (acc),
        .pend          (pend),
        .oam_rdata     (oam_rdata),
        .vram_rdata    (vram_rdata),
        .m_ready       (m_ready),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_read_data   (m_read_data),
        .m_nmi_request (m_nmi_request),
        .stat          (stat)
    );

`ifndef SYNTHESIS
    // An accepted word always lands in the wait stage
    a_accept_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> stat.pend_valid)
        else $error("accepted word missing from wait stage");

    // Memories are touched only by an accepted word
    a_mem_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.oam_en || req.vram_en) |-> (s_valid && s_ready))
        else $error("memory access without accept");

    // An interrupt request never comes with read data
    a_nmi_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nmi_request |-> m_read_data == 8'd0)
        else $error("interrupt request with nonzero read data");

    // A full wait stage facing a stalled output blocks input
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.pend_valid && m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline is stalled");
`endif

endmodule
